// File: rtl/gtst_pkg.sv
// Shared types and constants for the generation-tagged slot table.
package gtst_pkg;

   localparam int ID_W          = 31;
   localparam int SLOT_IN_W     = 10;
   localparam int STATUS_W      = 2;
   localparam int RUNS_W        = 32;
   localparam int OP_W          = 2;
   localparam int DEF_NUM_SLOTS = 1024;
   localparam int DEF_GEN_SHIFT = 12;
   localparam int QUEUE_DEPTH   = 2;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC  = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_FREE   = 2'd2,
      OP_RUN    = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_FREE = 2'd1,
      STATUS_BAD_ID  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SS_FREE     = 2'd0,
      SS_RUNNABLE = 2'd1,
      SS_RUNNING  = 2'd2
   } slot_state_type;

   typedef enum logic [1:0] {
      BK_CLEAR = 2'd0,
      BK_IDLE  = 2'd1,
      BK_EXEC  = 2'd2
   } back_state_type;

   // One classified request word as it travels from the front to the back.
   typedef struct packed {
      op_type               op;
      logic [ID_W-1:0]      id;
      logic [ID_W-1:0]      parent;
      logic [SLOT_IN_W-1:0] slot;
      logic                 check_parent;
      logic                 id_zero;
      logic                 slot_ok;
   } cmd_type;

endpackage

// File: rtl/generation_tagged_slot_table_core.sv
// Top level of the generation-tagged slot table: front end, queue and back end.
//
// This block keeps a table of NUM_SLOTS slots with a last-in first-out free list and
// generation-tagged identifiers. Each request word carries one of four operations:
// allocate pops the free-list head, stamps a new identifier (old identifier plus one
// generation step, index bits replaced by the slot index, restarting at the first
// generation when bit 31 would be reached) and records the parent identifier; lookup
// checks an identifier, optionally requiring the slot to be the current one or a child
// of it, and identifier zero returns the current slot; free pushes a slot back; run
// makes a slot current and counts how often it became so. Every request gives exactly
// one response word. After reset the block sweeps the slot memory once, one entry per
// cycle, and req_ready stays low until the sweep is done. After that the back end first
// reads the slot entry of each word from the slot memory, which has a registered read,
// then updates it and registers the response once the response register is free, and
// takes no new word before that update is done. A two-word queue sits between the front
// end and the back end, and the response register lets a new word be taken while an
// earlier response still waits for rsp_ready.
module generation_tagged_slot_table_core #(
   parameter int NUM_SLOTS = gtst_pkg::DEF_NUM_SLOTS,
   parameter int GEN_SHIFT = gtst_pkg::DEF_GEN_SHIFT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [gtst_pkg::OP_W-1:0]         req_opcode,
   input  logic [gtst_pkg::ID_W-1:0]         req_id_in,
   input  logic [gtst_pkg::ID_W-1:0]         req_parent_in,
   input  logic [gtst_pkg::SLOT_IN_W-1:0]    req_slot_in,
   input  logic                              req_check_parent,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [gtst_pkg::STATUS_W-1:0]     rsp_status,
   output logic                              rsp_found,
   output logic [gtst_pkg::SLOT_IN_W-1:0]    rsp_slot_out,
   output logic [gtst_pkg::ID_W-1:0]         rsp_id_out,
   output logic [gtst_pkg::ID_W-1:0]         rsp_parent_out,
   output logic [gtst_pkg::RUNS_W-1:0]       rsp_run_count
);
   import gtst_pkg::*;

   // Hand-off between the two halves: the queue head and the clearing flag.
   logic    clearing;
   logic    q_valid;
   logic    q_pop;
   cmd_type q_cmd;

   // The front end classifies each request and holds it until the back end is free.
   gtst_front #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_id_in        (req_id_in),
      .req_parent_in    (req_parent_in),
      .req_slot_in      (req_slot_in),
      .req_check_parent (req_check_parent),
      .clearing         (clearing),
      .q_valid          (q_valid),
      .q_cmd            (q_cmd),
      .q_pop            (q_pop)
   );

   // The back end owns the slot memory, the free-list head and the current slot.
   gtst_back #(
      .NUM_SLOTS (NUM_SLOTS),
      .GEN_SHIFT (GEN_SHIFT)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .clearing       (clearing),
      .q_valid        (q_valid),
      .q_cmd          (q_cmd),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_found      (rsp_found),
      .rsp_slot_out   (rsp_slot_out),
      .rsp_id_out     (rsp_id_out),
      .rsp_parent_out (rsp_parent_out),
      .rsp_run_count  (rsp_run_count)
   );

endmodule

// File: rtl/gtst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gtst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/gtst_front.sv
// Request front end: accepts words, classifies them and queues them for the back end.
module gtst_front #(
   parameter int NUM_SLOTS = gtst_pkg::DEF_NUM_SLOTS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [gtst_pkg::OP_W-1:0]         req_opcode,
   input  logic [gtst_pkg::ID_W-1:0]         req_id_in,
   input  logic [gtst_pkg::ID_W-1:0]         req_parent_in,
   input  logic [gtst_pkg::SLOT_IN_W-1:0]    req_slot_in,
   input  logic                              req_check_parent,
   input  logic                              clearing,
   output logic                              q_valid,
   output gtst_pkg::cmd_type                 q_cmd,
   input  logic                              q_pop
);
   import gtst_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   cmd_type          q_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   cmd_type          cmd_in;
   logic             push;

   // Classification: flag the identifier-zero lookup and slot indexes past the table.
   always_comb begin
      cmd_in.op           = op_type'(req_opcode);
      cmd_in.id           = req_id_in;
      cmd_in.parent       = req_parent_in;
      cmd_in.slot         = req_slot_in;
      cmd_in.check_parent = req_check_parent;
      cmd_in.id_zero      = (req_id_in == '0);
      cmd_in.slot_ok      = (32'(req_slot_in) < 32'(NUM_SLOTS));
   end

   assign req_ready = (count_ff != CNT_W'(QUEUE_DEPTH)) && !clearing;
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_cmd     = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

// File: rtl/gtst_back.sv
// Back end: clears the slot table, then runs each queued word as a read-modify-write.
module gtst_back #(
   parameter int NUM_SLOTS = gtst_pkg::DEF_NUM_SLOTS,
   parameter int GEN_SHIFT = gtst_pkg::DEF_GEN_SHIFT
) (
   input  logic                              clock,
   input  logic                              reset,
   output logic                              clearing,
   input  logic                              q_valid,
   input  gtst_pkg::cmd_type                 q_cmd,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [gtst_pkg::STATUS_W-1:0]     rsp_status,
   output logic                              rsp_found,
   output logic [gtst_pkg::SLOT_IN_W-1:0]    rsp_slot_out,
   output logic [gtst_pkg::ID_W-1:0]         rsp_id_out,
   output logic [gtst_pkg::ID_W-1:0]         rsp_parent_out,
   output logic [gtst_pkg::RUNS_W-1:0]       rsp_run_count
);
   import gtst_pkg::*;

   localparam int SLOT_W   = $clog2(NUM_SLOTS);
   localparam int NEXT_W   = SLOT_W + 1;
   localparam int ENTRY_W  = 2 + ID_W + ID_W + RUNS_W + NEXT_W;
   // Entry layout, low to high: next, runs, parent, id, state.
   localparam int RUNS_LO  = NEXT_W;
   localparam int PAR_LO   = RUNS_LO + RUNS_W;
   localparam int ID_LO    = PAR_LO + ID_W;
   localparam int ST_LO    = ID_LO + ID_W;
   localparam logic [NEXT_W-1:0] NONE_IDX = NEXT_W'(NUM_SLOTS);
   localparam logic [31:0] GEN_INC  = 32'd1 << GEN_SHIFT;
   localparam logic [31:0] GEN_MASK = ~(32'(NUM_SLOTS) - 32'd1);
   localparam logic [ID_W-1:0] IDX_MASK = ID_W'(NUM_SLOTS - 1);

   back_state_type     state_ff, state_in;
   logic [SLOT_W-1:0]  clr_ff, clr_in;
   logic [NEXT_W-1:0]  head_ff, head_in;
   logic               cur_valid_ff, cur_valid_in;
   logic [SLOT_W-1:0]  cur_slot_ff, cur_slot_in;
   logic [ID_W-1:0]    cur_id_ff, cur_id_in;
   cmd_type            cmd_ff, cmd_in;
   logic [SLOT_W-1:0]  addr_ff, addr_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         status_ff, status_in;
   logic               found_ff, found_in;
   logic [SLOT_IN_W-1:0] slot_out_ff, slot_out_in;
   logic [ID_W-1:0]    id_out_ff, id_out_in;
   logic [ID_W-1:0]    parent_out_ff, parent_out_in;
   logic [RUNS_W-1:0]  runs_out_ff, runs_out_in;

   logic               wr_en, rd_en;
   logic [SLOT_W-1:0]  wr_addr, rd_addr;
   logic [ENTRY_W-1:0] wr_data, rd_data;

   slot_state_type     e_state;
   logic [ID_W-1:0]    e_id;
   logic [ID_W-1:0]    e_parent;
   logic [RUNS_W-1:0]  e_runs;
   logic [NEXT_W-1:0]  e_next;
   logic [31:0]        gen_sum;
   logic [31:0]        gen_masked;
   logic [ID_W-1:0]    new_id;
   logic               out_free;

   gtst_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign e_state  = slot_state_type'(rd_data[ST_LO +: 2]);
   assign e_id     = rd_data[ID_LO +: ID_W];
   assign e_parent = rd_data[PAR_LO +: ID_W];
   assign e_runs   = rd_data[RUNS_LO +: RUNS_W];
   assign e_next   = rd_data[NEXT_W-1:0];

   // Next generation: bump above the index field, restart when bit 31 is reached.
   always_comb begin
      gen_sum    = {1'b0, e_id} + GEN_INC;
      gen_masked = gen_sum & GEN_MASK;
      if ((gen_masked == '0) || gen_masked[31]) begin
         gen_masked = GEN_INC;
      end
      new_id = gen_masked[ID_W-1:0] | ID_W'(addr_ff);
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      head_in       = head_ff;
      cur_valid_in  = cur_valid_ff;
      cur_slot_in   = cur_slot_ff;
      cur_id_in     = cur_id_ff;
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      status_in     = status_ff;
      found_in      = found_ff;
      slot_out_in   = slot_out_ff;
      id_out_in     = id_out_ff;
      parent_out_in = parent_out_ff;
      runs_out_in   = runs_out_ff;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = '0;
      q_pop         = 1'b0;
      clearing      = 1'b0;

      case (state_ff)
         BK_CLEAR: begin
            clearing = 1'b1;
            wr_en    = 1'b1;
            wr_addr  = clr_ff;
            wr_data  = {SS_FREE, {ID_W{1'b0}}, {ID_W{1'b0}}, {RUNS_W{1'b0}},
                        NEXT_W'({1'b0, clr_ff}) + NEXT_W'(1)};
            clr_in   = clr_ff + 1'b1;
            if (32'(clr_ff) == 32'(NUM_SLOTS - 1)) begin
               state_in = BK_IDLE;
            end
         end

         BK_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               rd_en  = 1'b1;
               cmd_in = q_cmd;
               case (q_cmd.op)
                  OP_ALLOC:  rd_addr = head_ff[SLOT_W-1:0];
                  OP_LOOKUP: rd_addr = q_cmd.id_zero ? cur_slot_ff
                                                     : SLOT_W'(q_cmd.id & IDX_MASK);
                  default:   rd_addr = SLOT_W'(q_cmd.slot);
               endcase
               addr_in  = rd_addr;
               state_in = BK_EXEC;
            end
         end

         BK_EXEC: begin
            if (out_free) begin
               state_in      = BK_IDLE;
               rsp_valid_in  = 1'b1;
               status_in     = STATUS_OK;
               found_in      = 1'b1;
               slot_out_in   = SLOT_IN_W'(32'(addr_ff));
               id_out_in     = e_id;
               parent_out_in = e_parent;
               runs_out_in   = e_runs;
               case (cmd_ff.op)
                  OP_ALLOC: begin
                     if (head_ff == NONE_IDX) begin
                        status_in = STATUS_NO_FREE;
                        found_in  = 1'b0;
                     end else begin
                        wr_en         = 1'b1;
                        wr_data       = {SS_RUNNABLE, new_id, cmd_ff.parent,
                                         {RUNS_W{1'b0}}, e_next};
                        head_in       = e_next;
                        id_out_in     = new_id;
                        parent_out_in = cmd_ff.parent;
                        runs_out_in   = '0;
                     end
                  end
                  OP_LOOKUP: begin
                     if (cmd_ff.id_zero) begin
                        found_in = cur_valid_ff;
                     end else if ((e_state == SS_FREE) || (e_id != cmd_ff.id)) begin
                        status_in = STATUS_BAD_ID;
                        found_in  = 1'b0;
                     end else if (cmd_ff.check_parent &&
                                  !(cur_valid_ff && (cur_slot_ff == addr_ff)) &&
                                  (!cur_valid_ff || (e_parent != cur_id_ff))) begin
                        status_in = STATUS_BAD_ID;
                        found_in  = 1'b0;
                     end
                  end
                  OP_FREE: begin
                     if (!cmd_ff.slot_ok || (e_state == SS_FREE)) begin
                        status_in = STATUS_BAD_ID;
                        found_in  = 1'b0;
                     end else begin
                        wr_en   = 1'b1;
                        wr_data = {SS_FREE, e_id, e_parent, e_runs, head_ff};
                        head_in = {1'b0, addr_ff};
                        if (cur_valid_ff && (cur_slot_ff == addr_ff)) begin
                           cur_valid_in = 1'b0;
                        end
                     end
                  end
                  OP_RUN: begin
                     if (!cmd_ff.slot_ok || (e_state == SS_FREE)) begin
                        status_in = STATUS_BAD_ID;
                        found_in  = 1'b0;
                     end else if (!(cur_valid_ff && (cur_slot_ff == addr_ff))) begin
                        wr_en        = 1'b1;
                        wr_data      = {SS_RUNNING, e_id, e_parent, e_runs + 1'b1, e_next};
                        cur_valid_in = 1'b1;
                        cur_slot_in  = addr_ff;
                        cur_id_in    = e_id;
                        runs_out_in  = e_runs + 1'b1;
                     end
                  end
                  default: begin
                     status_in = STATUS_BAD_ID;
                     found_in  = 1'b0;
                  end
               endcase
               if (!found_in) begin
                  slot_out_in   = '0;
                  id_out_in     = '0;
                  parent_out_in = '0;
                  runs_out_in   = '0;
               end
            end
         end

         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_ff       <= '0;
         head_ff      <= '0;
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_slot_ff   <= cur_slot_in;
      cur_id_ff     <= cur_id_in;
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      slot_out_ff   <= slot_out_in;
      id_out_ff     <= id_out_in;
      parent_out_ff <= parent_out_in;
      runs_out_ff   <= runs_out_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_found      = found_ff;
   assign rsp_slot_out   = slot_out_ff;
   assign rsp_id_out     = id_out_ff;
   assign rsp_parent_out = parent_out_ff;
   assign rsp_run_count  = runs_out_ff;

endmodule

// File: verif/generation_tagged_slot_table_core_tb.sv
// Self-checking testbench for the generation-tagged slot table core.
module generation_tagged_slot_table_core_tb;
   import gtst_pkg::*;

   // The block is built with its default sizes, so the shadow table uses the same ones.
   localparam int NUM_SLOTS      = DEF_NUM_SLOTS;
   localparam int GEN_SHIFT      = DEF_GEN_SHIFT;
   localparam int RESET_CYCLES   = 9;
   localparam int IDLE_PCT       = 15;
   localparam int RANDOM_WORDS   = 700;
   localparam int DRAIN_CYCLES   = 16;
   localparam int PRINT_CAP      = 40;
   // The clearing sweep after reset holds req_ready low while it writes every slot entry, so
   // the watchdog limit is set well above that sweep before it calls a stall a hang.
   localparam int WATCHDOG_LIMIT = 4 * NUM_SLOTS + 1000;
   localparam logic [ID_W-1:0] GEN_STEP = ID_W'(1 << GEN_SHIFT);
   localparam logic [ID_W-1:0] ID_MAX   = {ID_W{1'b1}};

   typedef struct {
      op_type               op;
      logic [ID_W-1:0]      id;
      logic [ID_W-1:0]      parent;
      logic [SLOT_IN_W-1:0] slot;
      logic                 check_parent;
   } table_req_type;

   typedef struct {
      status_type           status;
      logic                 found;
      logic [SLOT_IN_W-1:0] slot;
      logic [ID_W-1:0]      id;
      logic [ID_W-1:0]      parent;
      logic [RUNS_W-1:0]    runs;
   } slot_answer_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [OP_W-1:0]      req_opcode = '0;
   logic [ID_W-1:0]      req_id_in = '0;
   logic [ID_W-1:0]      req_parent_in = '0;
   logic [SLOT_IN_W-1:0] req_slot_in = '0;
   logic                 req_check_parent = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic                 rsp_found;
   logic [SLOT_IN_W-1:0] rsp_slot_out;
   logic [ID_W-1:0]      rsp_id_out;
   logic [ID_W-1:0]      rsp_parent_out;
   logic [RUNS_W-1:0]    rsp_run_count;

   // Words waiting to be driven, and the answers predicted for accepted words.
   table_req_type   pending_reqs[$];
   slot_answer_type answers_due[$];
   table_req_type   on_bus;
   int unsigned     live_slots[$];

   // While steady is set neither side idles, which gives one long stretch at full rate.
   logic steady = 1'b0;
   int   error_count = 0;
   int   rsp_seen = 0;
   int   quiet_cycles = 0;

   // Shadow copy of the slot table, updated once per accepted request word.
   slot_state_type    tbl_state [NUM_SLOTS];
   logic [ID_W-1:0]   tbl_id [NUM_SLOTS];
   logic [ID_W-1:0]   tbl_parent [NUM_SLOTS];
   logic [RUNS_W-1:0] tbl_runs [NUM_SLOTS];
   int unsigned       tbl_next [NUM_SLOTS];
   int unsigned       tbl_head;
   int unsigned       tbl_current;

   generation_tagged_slot_table_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_id_in        (req_id_in),
      .req_parent_in    (req_parent_in),
      .req_slot_in      (req_slot_in),
      .req_check_parent (req_check_parent),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_found        (rsp_found),
      .rsp_slot_out     (rsp_slot_out),
      .rsp_id_out       (rsp_id_out),
      .rsp_parent_out   (rsp_parent_out),
      .rsp_run_count    (rsp_run_count)
   );

   always #10 clock = ~clock;

   function automatic void reset_table();
      for (int i = 0; i < NUM_SLOTS; i++) begin
         tbl_state[i]  = SS_FREE;
         tbl_id[i]     = '0;
         tbl_parent[i] = '0;
         tbl_runs[i]   = '0;
         tbl_next[i]   = i + 1;
      end
      tbl_head    = 0;
      tbl_current = NUM_SLOTS;
   endfunction

   // A slot index at or above NUM_SLOTS stands for "no slot": every field then reads zero.
   function automatic slot_answer_type make_answer(status_type st, int unsigned s);
      slot_answer_type a;
      a.status = st;
      a.found  = 1'b0;
      a.slot   = '0;
      a.id     = '0;
      a.parent = '0;
      a.runs   = '0;
      if (s < NUM_SLOTS) begin
         a.found  = 1'b1;
         a.slot   = SLOT_IN_W'(s);
         a.id     = tbl_id[s];
         a.parent = tbl_parent[s];
         a.runs   = tbl_runs[s];
      end
      return a;
   endfunction

   // Applies one request word to the shadow table and returns the answer it must give.
   function automatic slot_answer_type resolve_request(table_req_type r);
      int unsigned s;
      logic [31:0] gen;
      case (r.op)
         OP_ALLOC: begin
            s = tbl_head;
            if (s >= NUM_SLOTS) begin
               return make_answer(STATUS_NO_FREE, NUM_SLOTS);
            end
            // The generation moves up one step with the index bits cleared; once it would
            // reach bit 31 it starts over at the first generation.
            gen = {1'b0, tbl_id[s]} + (32'd1 << GEN_SHIFT);
            gen = gen & ~32'(NUM_SLOTS - 1);
            if (gen == 32'd0 || gen > 32'h7FFF_FFFF) begin
               gen = 32'd1 << GEN_SHIFT;
            end
            tbl_id[s]     = ID_W'(gen | s);
            tbl_parent[s] = r.parent;
            tbl_runs[s]   = '0;
            tbl_state[s]  = SS_RUNNABLE;
            tbl_head      = tbl_next[s];
            return make_answer(STATUS_OK, s);
         end
         OP_LOOKUP: begin
            if (r.id == '0) begin
               return make_answer(STATUS_OK, tbl_current);
            end
            s = r.id & (NUM_SLOTS - 1);
            if (tbl_state[s] == SS_FREE || tbl_id[s] != r.id) begin
               return make_answer(STATUS_BAD_ID, NUM_SLOTS);
            end
            // With the parent check the slot must be the current one or its child.
            if (r.check_parent && s != tbl_current) begin
               if (tbl_current >= NUM_SLOTS || tbl_parent[s] != tbl_id[tbl_current]) begin
                  return make_answer(STATUS_BAD_ID, NUM_SLOTS);
               end
            end
            return make_answer(STATUS_OK, s);
         end
         default: begin
            s = 32'(r.slot);
            if (s >= NUM_SLOTS || tbl_state[s] == SS_FREE) begin
               return make_answer(STATUS_BAD_ID, NUM_SLOTS);
            end
            if (r.op == OP_FREE) begin
               if (tbl_current == s) begin
                  tbl_current = NUM_SLOTS;
               end
               tbl_state[s] = SS_FREE;
               tbl_next[s]  = tbl_head;
               tbl_head     = s;
               return make_answer(STATUS_OK, s);
            end
            // Running the current slot again changes nothing; running another one leaves
            // the previous current slot in its running state.
            if (tbl_current != s) begin
               tbl_current  = s;
               tbl_state[s] = SS_RUNNING;
               tbl_runs[s]  = tbl_runs[s] + 1'b1;
            end
            return make_answer(STATUS_OK, s);
         end
      endcase
   endfunction

   task automatic report(input string what);
      if (error_count < PRINT_CAP) begin
         $display("MISMATCH at response word %0d: %s", rsp_seen, what);
      end
      error_count++;
   endtask

   task automatic push_req(input op_type op, input logic [ID_W-1:0] id,
                           input logic [ID_W-1:0] parent,
                           input logic [SLOT_IN_W-1:0] slot, input logic chk);
      table_req_type r;
      r.op           = op;
      r.id           = id;
      r.parent       = parent;
      r.slot         = slot;
      r.check_parent = chk;
      pending_reqs.push_back(r);
   endtask

   function automatic void collect_live();
      live_slots.delete();
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (tbl_state[i] != SS_FREE) begin
            live_slots.push_back(i);
         end
      end
   endfunction

   // Mostly well-formed words built from the live slots: valid ids, children of the
   // current slot, frees and runs of allocated slots. The rest are stale generations,
   // random ids and slots that are already free. Fields an operation ignores are random.
   function automatic table_req_type random_req();
      table_req_type r;
      int unsigned   s;
      int unsigned   pick;
      int unsigned   sel;
      r.id           = ID_W'($urandom);
      r.parent       = ID_W'($urandom);
      r.slot         = SLOT_IN_W'($urandom);
      r.check_parent = 1'($urandom);
      if (live_slots.size() != 0) begin
         s = live_slots[$urandom_range(live_slots.size() - 1)];
      end else begin
         s = $urandom_range(NUM_SLOTS - 1);
      end
      pick = $urandom_range(99);
      sel  = $urandom_range(19);
      if (pick < 35) begin
         r.op = OP_ALLOC;
         if (sel < 10 && tbl_current < NUM_SLOTS) begin
            r.parent = tbl_id[tbl_current];
         end else if (sel < 14) begin
            r.parent = tbl_id[s];
         end
      end else if (pick < 65) begin
         r.op = OP_LOOKUP;
         if (sel < 2) begin
            r.id = '0;
         end else if (sel < 14) begin
            r.id = tbl_id[s];
         end else if (sel < 16) begin
            r.id = tbl_id[s] - GEN_STEP;
         end else if (sel < 18) begin
            r.id[SLOT_IN_W-1:0] = SLOT_IN_W'(s);
         end
      end else if (pick < 80) begin
         r.op = OP_FREE;
         if (sel < 16) begin
            r.slot = SLOT_IN_W'(s);
         end
      end else begin
         r.op = OP_RUN;
         if (sel < 14) begin
            r.slot = SLOT_IN_W'(s);
         end else if (sel < 17 && tbl_current < NUM_SLOTS) begin
            r.slot = SLOT_IN_W'(tbl_current);
         end
      end
      return r;
   endfunction

   // Waits until every word has been accepted and every answer has come back.
   task automatic drain_all();
      do begin
         @(negedge clock);
      end while (pending_reqs.size() != 0 || req_valid || answers_due.size() != 0);
   endtask

   // Words are generated in small batches from the table as it stands when the queue
   // runs dry, so a batch may free a slot that a later word of the same batch uses.
   task automatic random_phase(input int words, input int steady_from, input int steady_to);
      int n;
      int batch;
      n = 0;
      while (n < words) begin
         @(negedge clock);
         if (pending_reqs.size() == 0) begin
            steady = (n >= steady_from && n < steady_to);
            collect_live();
            batch = $urandom_range(8, 1);
            for (int k = 0; k < batch; k++) begin
               pending_reqs.push_back(random_req());
            end
            n += batch;
         end
      end
      steady = 1'b0;
   endtask

   // Driver: a new word goes out whenever the bus is free after this edge, unless the
   // sender chooses to idle. The predictor runs on each word as it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            answers_due.push_back(resolve_request(on_bus));
         end
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
               on_bus           = pending_reqs.pop_front();
               req_valid        <= 1'b1;
               req_opcode       <= on_bus.op;
               req_id_in        <= on_bus.id;
               req_parent_in    <= on_bus.parent;
               req_slot_in      <= on_bus.slot;
               req_check_parent <= on_bus.check_parent;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: each accepted response word is checked field by field against the oldest
   // predicted answer; rsp_ready is stalled at random.
   always @(posedge clock) begin
      slot_answer_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               report("response word arrived with no request outstanding");
            end else begin
               want = answers_due.pop_front();
               if (rsp_status !== want.status) begin
                  report($sformatf("status %0d, expected %0d", rsp_status, want.status));
               end
               if (rsp_found !== want.found) begin
                  report($sformatf("found %0b, expected %0b", rsp_found, want.found));
               end
               if (rsp_slot_out !== want.slot) begin
                  report($sformatf("slot_out %0d, expected %0d", rsp_slot_out, want.slot));
               end
               if (rsp_id_out !== want.id) begin
                  report($sformatf("id_out %h, expected %h", rsp_id_out, want.id));
               end
               if (rsp_parent_out !== want.parent) begin
                  report($sformatf("parent_out %h, expected %h", rsp_parent_out, want.parent));
               end
               if (rsp_run_count !== want.runs) begin
                  report($sformatf("run_count %0d, expected %0d", rsp_run_count, want.runs));
               end
            end
            rsp_seen++;
         end
         rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Watchdog: counts cycles in which no word moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("generation_tagged_slot_table_core test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int          spare;
      int          j;
      int unsigned t;

      reset_table();

      // Directed words, written against the table as it is right after reset: slots 0, 1
      // and 2 are allocated first and get the first generation.
      push_req(OP_LOOKUP, '0, '0, '0, 1'b0);                 // id zero with no current slot
      push_req(OP_LOOKUP, ID_MAX, ID_MAX, '1, 1'b1);         // unknown id, parent check
      push_req(OP_RUN, '0, '0, 10'd5, 1'b0);                 // run of a free slot
      push_req(OP_FREE, '0, '0, '1, 1'b0);                   // free of a free slot
      push_req(OP_ALLOC, '0, '0, '0, 1'b0);                  // slot 0
      push_req(OP_ALLOC, ID_MAX, ID_MAX, '1, 1'b1);          // slot 1, all-ones parent
      push_req(OP_ALLOC, '0, GEN_STEP, '0, 1'b0);            // slot 2, child of slot 0
      push_req(OP_LOOKUP, GEN_STEP | ID_W'(1), '0, '0, 1'b0); // plain valid lookup
      push_req(OP_LOOKUP, GEN_STEP | ID_W'(2), '0, '0, 1'b1); // parent check, no current
      push_req(OP_RUN, '0, '0, 10'd0, 1'b0);                 // slot 0 becomes current
      push_req(OP_LOOKUP, GEN_STEP | ID_W'(2), '0, '0, 1'b1); // child of current passes
      push_req(OP_LOOKUP, GEN_STEP | ID_W'(1), '0, '0, 1'b1); // not a child of current
      push_req(OP_LOOKUP, GEN_STEP, '0, '0, 1'b1);           // the current slot itself
      push_req(OP_LOOKUP, '0, '0, '0, 1'b1);                 // id zero gives current
      push_req(OP_RUN, '0, '0, 10'd0, 1'b0);                 // already current: no change
      push_req(OP_RUN, '0, '0, 10'd1, 1'b0);                 // slot 0 stays running
      push_req(OP_RUN, '0, '0, 10'd0, 1'b0);                 // second run of slot 0
      push_req(OP_FREE, '0, '0, 10'd0, 1'b0);                // free of the current slot
      push_req(OP_LOOKUP, GEN_STEP, '0, '0, 1'b0);           // freed slot is stale
      push_req(OP_LOOKUP, '0, '0, '0, 1'b0);                 // no current slot again
      push_req(OP_ALLOC, '0, ID_MAX, '0, 1'b0);              // slot 0 reused, next generation
      push_req(OP_LOOKUP, GEN_STEP, '0, '0, 1'b0);           // old generation rejected
      push_req(OP_FREE, '0, '0, 10'd0, 1'b0);
      push_req(OP_FREE, '0, '0, 10'd0, 1'b0);                // double free

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // The first pause: nothing more is sent until every directed answer is back.
      drain_all();
      random_phase(RANDOM_WORDS / 2, RANDOM_WORDS / 8, RANDOM_WORDS / 3);
      drain_all();
      random_phase(RANDOM_WORDS / 2, -1, -1);
      drain_all();

      // Exhaust the free list, try a few allocations beyond it, then give every slot back
      // in a random order with lookups mixed in, and reuse a few slots.
      collect_live();
      spare = NUM_SLOTS - live_slots.size();
      for (int k = 0; k < spare + 3; k++) begin
         push_req(OP_ALLOC, ID_W'($urandom), ID_W'($urandom), SLOT_IN_W'($urandom),
                  1'($urandom));
      end
      drain_all();
      collect_live();
      for (int k = live_slots.size() - 1; k > 0; k--) begin
         j = $urandom_range(k);
         t = live_slots[k];
         live_slots[k] = live_slots[j];
         live_slots[j] = t;
      end
      for (int k = 0; k < live_slots.size(); k++) begin
         push_req(OP_FREE, ID_W'($urandom), ID_W'($urandom), SLOT_IN_W'(live_slots[k]),
                  1'($urandom));
         if (k % 8 == 7 && k + 1 < live_slots.size()) begin
            push_req(OP_LOOKUP, tbl_id[live_slots[k + 1]], ID_W'($urandom),
                     SLOT_IN_W'($urandom), 1'($urandom));
         end
      end
      push_req(OP_FREE, '0, '0, SLOT_IN_W'(live_slots[0]), 1'b0);
      for (int k = 0; k < 4; k++) begin
         push_req(OP_ALLOC, '0, ID_W'($urandom), '0, 1'b0);
      end
      drain_all();
      random_phase(RANDOM_WORDS / 10, -1, -1);
      drain_all();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("generation_tagged_slot_table_core test passed");
      end else begin
         $display("generation_tagged_slot_table_core test failed");
      end
      $finish;
   end

endmodule
